>>> sv/per_key_sliding_window_rate_limiter_macros.svh
// Assertion macros for the per-key sliding-window rate limiter.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PER_KEY_SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
`define PER_KEY_SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on the rising edge, off during reset.
`define PKSWRL_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on the rising edge, off during reset.
`define PKSWRL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PKSWRL_ASSERT_NOW(name, clk, rst, ante, cons, msg)
`define PKSWRL_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/pkswrl_pkg.sv
// Shared constants, types and control structs of the rate limiter.
// No dependencies; imported by the controller, the datapath and the top level.
package pkswrl_pkg;

  localparam int SLOTS             = 8;
  localparam int EVENTS_PER_WINDOW = 2;

  localparam int KEY_W  = 64;
  localparam int TIME_W = 32;
  localparam int WIN_W  = 17;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W  = (EVENTS_PER_WINDOW > 1) ? $clog2(EVENTS_PER_WINDOW) : 1;
  localparam int CNT_W  = $clog2(EVENTS_PER_WINDOW + 1);

  // Result field widths and packed stream widths
  localparam int OUT_SLOT_W = 3;
  localparam int OUT_CNT_W  = 2;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 8;

  localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(120);
  localparam logic [TIME_W-1:0] STAMP_MAX    = {TIME_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MATCH  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic match;
    logic scan;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/pkswrl_ctrl.sv
// Controller state machine of the rate limiter: sequences lookup, victim scan and update.
// Depends on pkswrl_pkg.
module pkswrl_ctrl import pkswrl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_axis_tvalid,
  output logic     s_axis_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through lookup, optional scan and update
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_MATCH;
      end
      ST_MATCH: begin
        state_next = stat.need_scan ? ST_SCAN : ST_UPDATE;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);

  // Drive datapath commands
  always_comb begin
    cmd.load_in = (state == ST_IDLE) && s_axis_tvalid;
    cmd.match   = (state == ST_MATCH);
    cmd.scan    = (state == ST_SCAN);
    cmd.commit  = (state == ST_UPDATE) && stat.out_free;
  end

endmodule

>>> sv/pkswrl_dp.sv
// Datapath of the rate limiter: slot table, key match, victim scan, window count, result register.
// Depends on pkswrl_pkg.
module pkswrl_dp import pkswrl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [WIN_W-1:0]      cfg_data,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [WIN_W-1:0]  window;
  logic [SLOTS-1:0]  slot_valid;
  logic [KEY_W-1:0]  slot_key [SLOTS];
  logic [TIME_W-1:0] slot_stamps [SLOTS][EVENTS_PER_WINDOW];
  logic [PTR_W-1:0]  slot_ring_pointer [SLOTS];

  logic [KEY_W-1:0]  in_key;
  logic [TIME_W-1:0] in_now;

  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic              free;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] scan_idx;
  logic [TIME_W-1:0] best;
  logic [SLOT_W-1:0] best_idx;

  logic [SLOTS-1:0]  hit_vec;
  logic [SLOT_W-1:0] hit_first;
  logic [SLOT_W-1:0] free_first;

  logic [SLOT_W-1:0] sel;
  logic [SLOT_W-1:0] rd_idx;
  logic              claim;
  logic [TIME_W-1:0] row_min;
  logic [TIME_W-1:0] cur_stamp [EVENTS_PER_WINDOW];
  logic [PTR_W-1:0]  cur_ptr;
  logic [PTR_W-1:0]  next_ptr;
  logic [EVENTS_PER_WINDOW-1:0] recent;
  logic [CNT_W-1:0]  count;
  logic              limited;
  logic [TIME_W-1:0] win_ext;

  assign cfg_ready = 1'b1;
  assign win_ext   = {{(TIME_W-WIN_W){1'b0}}, window};

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_valid) begin
      window <= cfg_data;
    end
  end

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_key <= s_axis_tdata[KEY_W-1:0];
      in_now <= s_axis_tdata[KEY_W+TIME_W-1:KEY_W];
    end
  end

  // Compare the key against every slot, pick the lowest hit and the lowest free slot
  always_comb begin
    hit_first  = '0;
    free_first = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      hit_vec[i] = slot_valid[i] && (slot_key[i] == in_key);
      if (hit_vec[i]) hit_first = SLOT_W'(i);
      if (!slot_valid[i]) free_first = SLOT_W'(i);
    end
  end

  assign stat.need_scan = !(|hit_vec) && (&slot_valid);
  assign stat.scan_last = (scan_idx == SLOT_W'(SLOTS - 1));
  assign stat.out_free  = !m_axis_tvalid || m_axis_tready;

  // Serving slot and one shared row read for scan and update
  assign sel    = hit ? hit_idx : (free ? free_idx : best_idx);
  assign claim  = !hit;
  assign rd_idx = cmd.scan ? scan_idx : sel;

  // Least stamp of the row under scan
  always_comb begin
    row_min = slot_stamps[rd_idx][0];
    for (int j = 1; j < EVENTS_PER_WINDOW; j++) begin
      if (slot_stamps[rd_idx][j] < row_min) row_min = slot_stamps[rd_idx][j];
    end
  end

  // Latch lookup results, then walk the slots keeping the least stamp
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit      <= |hit_vec;
      hit_idx  <= hit_first;
      free     <= !(&slot_valid);
      free_idx <= free_first;
      scan_idx <= '0;
      best     <= STAMP_MAX;
      best_idx <= '0;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + SLOT_W'(1);
      if (row_min < best) begin
        best     <= row_min;
        best_idx <= scan_idx;
      end
    end
  end

  // Count recent stamps of the serving slot; a claimed slot starts empty
  always_comb begin
    for (int j = 0; j < EVENTS_PER_WINDOW; j++) begin
      cur_stamp[j] = claim ? '0 : slot_stamps[rd_idx][j];
      recent[j]    = (cur_stamp[j] != '0) && ((in_now - cur_stamp[j]) < win_ext);
    end
    cur_ptr  = claim ? '0 : slot_ring_pointer[rd_idx];
    next_ptr = (cur_ptr == PTR_W'(EVENTS_PER_WINDOW - 1)) ? '0 : cur_ptr + PTR_W'(1);
    count    = CNT_W'($countones(recent));
    limited  = (count >= CNT_W'(EVENTS_PER_WINDOW));
  end

  // Slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.commit && claim) begin
      slot_valid[sel] <= 1'b1;
    end
  end

  // Update key, stamps and ring pointer of the serving slot
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (claim) slot_key[sel] <= in_key;
      for (int j = 0; j < EVENTS_PER_WINDOW; j++) begin
        if (!limited && (cur_ptr == PTR_W'(j))) begin
          slot_stamps[sel][j] <= in_now;
        end else if (claim) begin
          slot_stamps[sel][j] <= '0;
        end
      end
      slot_ring_pointer[sel] <= limited ? cur_ptr : next_ptr;
    end
  end

  // Result register: load on commit, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_axis_tdata <= {1'b0, OUT_CNT_W'(count), claim, OUT_SLOT_W'(sel), limited};
    end
  end

endmodule

>>> sv/per_key_sliding_window_rate_limiter.sv
// Per-key sliding-window rate limiter: top level joining controller and datapath.
// Request and result channels are stream beats; window_seconds is written on the cfg channel.
// Depends on pkswrl_pkg, pkswrl_ctrl, pkswrl_dp and the assertion macro header.
//
// Each request beat carries a 64-bit key and the time in seconds. The key is looked up
// in an 8-slot table; a miss claims the first free slot or, with the table full, evicts
// the slot whose least stamp is smallest. The request is refused when the slot already
// holds EVENTS_PER_WINDOW stamps younger than the window; otherwise it is recorded.
// An accepted request passes the match state, the scan state only when a victim must
// be found, and the update state, which loads the result register; the victim scan reads
// one slot row per cycle. One request is in flight at a time. The request side is ready
// again as soon as the result is in the output register; a stalled receiver holds the
// result there and only blocks the next update.
// cfg_ready is always high; write the window only while no request is in flight.
// Reset (rst, synchronous) empties the table and sets the window to 120 seconds; no
// clearing pass is needed.
`include "per_key_sliding_window_rate_limiter_macros.svh"
module per_key_sliding_window_rate_limiter import pkswrl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [WIN_W-1:0]      cfg_data,       // window_seconds
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [63:0] chat_key, [95:64] now_seconds
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [0] limited, [3:1] slot_index,
                                                // [4] slot_claimed, [6:5] recent_count, [7] zero
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pkswrl_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  pkswrl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // One request in flight: accepting a beat closes the request side
  `PKSWRL_ASSERT_NEXT(a_one_in_flight, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")
  // A new result appears only from an update commit
  `PKSWRL_ASSERT_NOW(a_result_from_commit, clk, rst, $rose(m_axis_tvalid), $past(cmd.commit), "result without commit")
  // A refused request saw a full window of recent stamps
  `PKSWRL_ASSERT_NOW(a_limit_count, clk, rst, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[6:5] == OUT_CNT_W'(EVENTS_PER_WINDOW), "refused below limit")

endmodule
